FILE: hdl/rdp_pkg.sv
// ----------------------------------------------------------------------------
// Random draw pool package
// Shared sizes, operation and status codes, and controller states.
// ----------------------------------------------------------------------------
package rdp_pkg;

  // Number of distinct items held in the pool.
  localparam int POOL_SIZE = 52;

  // Field widths of the request and result channels.
  localparam int KIND_W   = 2;
  localparam int WORD_W   = 32;
  localparam int ITEM_W   = 6;
  localparam int STATUS_W = 2;

  // Slot index, live count and bit counter widths.
  localparam int IDX_W  = $clog2(POOL_SIZE);
  localparam int CNT_W  = $clog2(POOL_SIZE + 1);
  localparam int BITS_W = $clog2(WORD_W);

  typedef enum logic [KIND_W-1:0] {
    KIND_REFILL = 2'd0,
    KIND_DRAW   = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_TAKE,
    S_CHK,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_e;

endpackage

FILE: hdl/random_draw_pool_core.sv
// ----------------------------------------------------------------------------
// Random draw pool core
// Pool of distinct item numbers held in a slot memory with a live count.
// ----------------------------------------------------------------------------
// Usage
//   The request channel (in_valid_i / in_stall_o) carries kind_i,
//   random_word_i and item_value_i. A request is taken when in_valid_i is
//   high and in_stall_o is low. Kind 0 refills the pool, kind 1 draws the
//   slot at random_word_i modulo the live count, kind 2 removes a given
//   item number, kind 3 does nothing. Every request yields one result on the
//   result channel (out_valid_o / out_stall_i) with item_out_o, status_o and
//   live_count_o; the result register holds still while out_stall_i is high.
//   One request is worked on at a time. The result register is loaded as
//   the controller returns to idle; refill and the trivial cases go straight
//   to that load. A draw runs the bit-serial remainder unit (one bit of the
//   32-bit word per cycle), then the read, read-last and write-back accesses
//   to the slot memory. A remove first tries the slot equal to the value
//   when that lies below the live count; if the slot does not hold it, the
//   scan reads one live slot per cycle through the single memory read port.
//   A new request is accepted while a finished result still waits in the
//   result register; the controller then waits only if it must load the
//   next result before the previous one has been taken.
//   Reset empties the result register and acts as a refill: slot i holds
//   item i and the live count is full. No clearing pass is needed, because
//   a per-slot written flag makes an unwritten slot read as its own index.
// ----------------------------------------------------------------------------
module random_draw_pool_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rdp_pkg::KIND_W-1:0]    kind_i,
  input  logic [rdp_pkg::WORD_W-1:0]    random_word_i,
  input  logic [rdp_pkg::ITEM_W-1:0]    item_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rdp_pkg::ITEM_W-1:0]    item_out_o,
  output logic [rdp_pkg::STATUS_W-1:0]  status_o,
  output logic [rdp_pkg::ITEM_W-1:0]    live_count_o
);
  import rdp_pkg::*;

  // Controller state and working registers.
  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [WORD_W-1:0]   word_q, word_d;
  logic [ITEM_W-1:0]   value_q, value_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [BITS_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [IDX_W-1:0]    slot_q, slot_d;
  logic [ITEM_W-1:0]   item_q, item_d;
  status_e             res_status_q, res_status_d;

  // Result register.
  logic                out_valid_q;
  logic [ITEM_W-1:0]   out_item_q;
  status_e             out_status_q;
  logic [ITEM_W-1:0]   out_count_q;
  logic                out_load;

  // Slot memory and its per-slot written flags.
  logic [ITEM_W-1:0]   mem_q [POOL_SIZE];
  logic [POOL_SIZE-1:0] vld_q;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [ITEM_W-1:0]   rd_data_q;
  logic                rd_vld_q;
  logic [IDX_W-1:0]    rd_addr_q;
  logic                wr_en;
  logic                vld_clr;
  logic [ITEM_W-1:0]   entry;

  logic                in_accept;
  logic [CNT_W:0]      trial;
  logic [CNT_W-1:0]    cnt_dec;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // A slot never written since the last refill holds its own index.
  assign entry   = rd_vld_q ? rd_data_q : ITEM_W'(rd_addr_q);
  assign cnt_dec = cnt_q - CNT_W'(1);

  // One restoring step of the remainder: shift in the next word bit and
  // subtract the live count when it fits.
  assign trial = {rem_q, word_q[WORD_W-1]};

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    word_d       = word_q;
    value_d      = value_q;
    rem_d        = rem_q;
    bit_cnt_d    = bit_cnt_q;
    slot_d       = slot_q;
    item_d       = item_q;
    res_status_d = res_status_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    vld_clr      = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          word_d       = random_word_i;
          value_d      = item_value_i;
          item_d       = '0;
          res_status_d = ST_OK;
          unique case (kind_e'(kind_i))
            KIND_REFILL: begin
              vld_clr = 1'b1;
              cnt_d   = CNT_W'(POOL_SIZE);
              state_d = S_DONE;
            end
            KIND_DRAW: begin
              if (cnt_q == '0) begin
                res_status_d = ST_EMPTY;
                state_d      = S_DONE;
              end else begin
                rem_d     = '0;
                bit_cnt_d = BITS_W'(WORD_W - 1);
                state_d   = S_DIV;
              end
            end
            KIND_REMOVE: begin
              if (cnt_q == '0) begin
                res_status_d = ST_NOT_FOUND;
                state_d      = S_DONE;
              end else if (CNT_W'(item_value_i) < cnt_q) begin
                // Try the slot whose index equals the value first.
                rd_en   = 1'b1;
                rd_addr = IDX_W'(item_value_i);
                state_d = S_CHK;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                state_d = S_SCAN;
              end
            end
            KIND_NOP: begin
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_DIV: begin
        if (trial >= {1'b0, cnt_q}) begin
          rem_d = CNT_W'(trial - {1'b0, cnt_q});
        end else begin
          rem_d = CNT_W'(trial);
        end
        word_d    = {word_q[WORD_W-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - BITS_W'(1);
        if (bit_cnt_q == '0) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(rem_d);
          state_d = S_TAKE;
        end
      end

      S_TAKE: begin
        item_d  = entry;
        slot_d  = rd_addr_q;
        cnt_d   = cnt_dec;
        rd_en   = 1'b1;
        rd_addr = IDX_W'(cnt_dec);
        state_d = S_LAST;
      end

      S_CHK: begin
        if (entry == value_q) begin
          item_d  = entry;
          slot_d  = rd_addr_q;
          cnt_d   = cnt_dec;
          rd_en   = 1'b1;
          rd_addr = IDX_W'(cnt_dec);
          state_d = S_LAST;
        end else begin
          rd_en   = 1'b1;
          rd_addr = '0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // Data for rd_addr_q arrives while the next slot is read.
        if (entry == value_q) begin
          item_d  = entry;
          slot_d  = rd_addr_q;
          cnt_d   = cnt_dec;
          rd_en   = 1'b1;
          rd_addr = IDX_W'(cnt_dec);
          state_d = S_LAST;
        end else if (CNT_W'(rd_addr_q) == cnt_dec) begin
          item_d       = '0;
          res_status_d = ST_NOT_FOUND;
          state_d      = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_addr_q + IDX_W'(1);
        end
      end

      S_LAST: begin
        // Move the last live item into the freed slot.
        wr_en   = 1'b1;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= CNT_W'(POOL_SIZE);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q       <= word_d;
    value_q      <= value_d;
    rem_q        <= rem_d;
    bit_cnt_q    <= bit_cnt_d;
    slot_q       <= slot_d;
    item_q       <= item_d;
    res_status_q <= res_status_d;
  end

  // Slot memory: one read port with registered data, one write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[slot_q] <= entry;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (vld_clr) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[slot_q] <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q   <= item_q;
      out_status_q <= res_status_q;
      out_count_q  <= ITEM_W'(cnt_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign item_out_o   = out_item_q;
  assign status_o     = out_status_q;
  assign live_count_o = out_count_q;

  // The live count never exceeds the pool size.
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(POOL_SIZE))
    else $error("live count above pool size");

  // The scan only looks at live slots.
  a_scan_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CNT_W'(rd_addr_q) < cnt_q))
    else $error("scan beyond live slots");

  // An empty-pool result reports a zero count and no item.
  a_empty_res : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_EMPTY) |->
      (out_count_q == '0 && out_item_q == '0))
    else $error("empty status with live items");

  // A write-back only goes to a slot at or below the new live count.
  a_wr_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (CNT_W'(slot_q) <= cnt_q))
    else $error("write-back outside live slots");

endmodule

FILE: bench/random_draw_pool_core_checker.sv
// ----------------------------------------------------------------------------
// Random draw pool checker
// Watches both channels of the core. It keeps its own copy of the pool,
// predicts the reply to each accepted request, and compares every accepted
// result with the oldest reply still due.
// ----------------------------------------------------------------------------
module random_draw_pool_core_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [rdp_pkg::KIND_W-1:0]    kind_i,
  input  logic [rdp_pkg::WORD_W-1:0]    random_word_i,
  input  logic [rdp_pkg::ITEM_W-1:0]    item_value_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [rdp_pkg::ITEM_W-1:0]    item_out_i,
  input  logic [rdp_pkg::STATUS_W-1:0]  status_i,
  input  logic [rdp_pkg::ITEM_W-1:0]    live_count_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   due_count_o,
  output int unsigned                   checked_count_o,
  output int unsigned                   empty_draws_o,
  output int unsigned                   absent_removes_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rdp_pkg::*;

  typedef struct packed {
    logic [ITEM_W-1:0] item;
    status_e           status;
    logic [ITEM_W-1:0] count;
  } pool_reply_t;

  logic [ITEM_W-1:0] slot_items [POOL_SIZE];
  int unsigned       live_items;
  pool_reply_t       replies_due [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    fail_count_o++;
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      slot_items[i] = ITEM_W'(i);
    end
    live_items = POOL_SIZE;
  endtask

  // Applies one request to the local pool and returns the reply it must give.
  task automatic apply_pool_op(input kind_e op, input logic [WORD_W-1:0] word,
                               input logic [ITEM_W-1:0] value,
                               output pool_reply_t reply);
    int unsigned slot;
    int unsigned i;
    bit          hit;
    reply.item   = '0;
    reply.status = ST_OK;
    slot = 0;
    hit  = 1'b0;
    case (op)
      KIND_REFILL: begin
        refill_pool();
      end
      KIND_DRAW: begin
        if (live_items == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          slot = word % live_items;
          hit  = 1'b1;
        end
      end
      KIND_REMOVE: begin
        // The slot named by the value is tried before the scan.
        if (value < live_items && slot_items[value] == value) begin
          slot = value;
          hit  = 1'b1;
        end else begin
          for (i = 0; i < live_items && !hit; i++) begin
            if (slot_items[i] == value) begin
              slot = i;
              hit  = 1'b1;
            end
          end
        end
        if (!hit) begin
          reply.status = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    if (hit) begin
      reply.item = slot_items[slot];
      live_items--;
      slot_items[slot] = slot_items[live_items];
    end
    reply.count = ITEM_W'(live_items);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pool_reply_t want;
    pool_reply_t fresh;
    if (!rst_ni) begin
      refill_pool();
      replies_due.delete();
      due_count_o <= 0;
    end else begin
      // The result side is handled first: a result taken at this edge
      // always belongs to an earlier request.
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf(
            "result item %0d status %0d count %0d with no request waiting",
            item_out_i, status_i, live_count_i));
        end else begin
          want = replies_due.pop_front();
          checked_count_o++;
          if (item_out_i !== want.item) begin
            report_mismatch($sformatf("item_out %0d, expected %0d", item_out_i, want.item));
          end
          if (status_i !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", status_i, want.status));
          end
          if (live_count_i !== want.count) begin
            report_mismatch($sformatf("live_count %0d, expected %0d",
                                      live_count_i, want.count));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_pool_op(kind_e'(kind_i), random_word_i, item_value_i, fresh);
        if (fresh.status == ST_EMPTY) begin
          empty_draws_o++;
        end
        if (fresh.status == ST_NOT_FOUND) begin
          absent_removes_o++;
        end
        replies_due.push_back(fresh);
      end
      due_count_o <= replies_due.size();
    end
  end

endmodule

FILE: bench/random_draw_pool_core_tb.sv
// ----------------------------------------------------------------------------
// Random draw pool core testbench
// Drives refill, draw, remove and no-op requests into the core with random
// gaps and random result stalls. A separate checker predicts each reply and
// counts mismatches; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module random_draw_pool_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rdp_pkg::*;

  // Roughly how many requests the random part sends before it stops.
  localparam int unsigned REQUEST_TARGET = 1300;
  // Longest path through the core is a remove that scans every slot.
  localparam int unsigned TAIL_CYCLES = 80;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [KIND_W-1:0]    kind_i = KIND_NOP;
  logic [WORD_W-1:0]    random_word_i = '0;
  logic [ITEM_W-1:0]    item_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [ITEM_W-1:0]    item_out_o;
  logic [STATUS_W-1:0]  status_o;
  logic [ITEM_W-1:0]    live_count_o;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned checked_count;
  int unsigned empty_draws;
  int unsigned absent_removes;

  // When calm is set, neither side idles: requests go back to back and
  // results are taken as soon as they appear.
  bit          calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned sent_total = 0;
  int unsigned sent_by_kind [4];

  random_draw_pool_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .random_word_i (random_word_i),
    .item_value_i  (item_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .item_out_o    (item_out_o),
    .status_o      (status_o),
    .live_count_o  (live_count_o)
  );

  random_draw_pool_core_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .kind_i           (kind_i),
    .random_word_i    (random_word_i),
    .item_value_i     (item_value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .item_out_i       (item_out_o),
    .status_i         (status_o),
    .live_count_i     (live_count_o),
    .fail_count_o     (fail_count),
    .due_count_o      (due_count),
    .checked_count_o  (checked_count),
    .empty_draws_o    (empty_draws),
    .absent_removes_o (absent_removes)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the core hangs or a result never shows up.
  initial begin
    #10ms;
    $display("random_draw_pool_core_tb failed");
    $finish;
  end

  // Result side stall. Most cycles take the result at once, some stall for a
  // few cycles, and a few hold the result back for a long stretch so that
  // the core has to wait with a finished result in its output register.
  always @(posedge clk_i or negedge rst_ni) begin : result_stall
    int unsigned roll;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (calm) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        out_stall_i <= 1'b0;
      end else if (roll < 95) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(2, 0);
      end else begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(40, 10);
      end
    end
  end

  // Idle cycles before the next request: mostly none or a few, now and then
  // a long pause.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (calm || roll < 50) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  // Random words lean on the two extremes now and then so that the modulo
  // sees both all zeros and all ones.
  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) begin
      return '0;
    end
    if (roll == 1) begin
      return '1;
    end
    return $urandom;
  endfunction

  // Sends one request and returns right after the edge that accepts it.
  // Valid stays high when the next request follows with no gap, so it is
  // never lowered and raised again in the same time step.
  task automatic send_request(input kind_e op, input logic [WORD_W-1:0] word,
                              input logic [ITEM_W-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= op;
    random_word_i <= word;
    item_value_i  <= value;
    do @(posedge clk_i); while (in_stall_o);
    sent_total++;
    sent_by_kind[op]++;
  endtask

  task automatic send_draw(input logic [WORD_W-1:0] word);
    send_request(KIND_DRAW, word, ITEM_W'($urandom));
  endtask

  task automatic send_remove(input logic [ITEM_W-1:0] value);
    send_request(KIND_REMOVE, $urandom, value);
  endtask

  // The sender holds off until the checker has seen every reply it expects.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_count != 0);
  endtask

  // One random request of a well formed episode: mostly draws and removes
  // of item numbers that can be in the pool, with a few out of range
  // removes, no-ops and refills mixed in.
  task automatic send_random_op();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 48) begin
      send_draw(pick_word());
    end else if (roll < 88) begin
      send_remove(ITEM_W'($urandom_range(POOL_SIZE - 1)));
    end else if (roll < 94) begin
      send_remove(ITEM_W'($urandom_range(63, POOL_SIZE)));
    end else if (roll < 98) begin
      send_request(KIND_NOP, $urandom, ITEM_W'($urandom));
    end else begin
      send_request(KIND_REFILL, $urandom, ITEM_W'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned ops;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. After reset the pool is full and in identity order.
    send_request(KIND_NOP, '1, '1);
    // Drawing slot 0 moves the last item, 51, into slot 0.
    send_draw('0);
    // All ones is a multiple of 51, so slot 0 is drawn again and takes 51.
    send_draw('1);
    // Item 51 is gone, so the remove scans every live slot and fails.
    send_remove(ITEM_W'(51));
    // Item 0 has been drawn already.
    send_remove('0);
    // Item 10 should still sit in its own slot.
    send_remove(ITEM_W'(10));
    // Values beyond the pool are never found.
    send_remove(ITEM_W'(POOL_SIZE));
    send_remove('1);
    send_remove(ITEM_W'(42));
    send_remove(ITEM_W'(21));
    send_draw(32'h8000_0000);
    send_draw(32'h5555_5555);
    send_draw(32'hAAAA_AAAA);
    send_request(KIND_REFILL, '1, '1);
    // On a full pool the last item and the first item sit in their own slots.
    send_remove(ITEM_W'(POOL_SIZE - 1));
    send_remove('0);
    send_request(KIND_NOP, '0, '0);
    wait_until_drained();

    // Empty the pool completely, then try every kind of request on it.
    send_request(KIND_REFILL, $urandom, ITEM_W'($urandom));
    repeat (POOL_SIZE) send_draw(pick_word());
    send_draw('1);
    send_remove(ITEM_W'(7));
    send_remove('1);
    send_request(KIND_NOP, $urandom, ITEM_W'($urandom));
    send_request(KIND_REFILL, $urandom, ITEM_W'($urandom));
    wait_until_drained();

    // Random part, in episodes. Most are well formed: usually a refill, then
    // enough draws and removes to take the pool deep, often down to empty.
    // The rest are noise with any kind and any field values.
    while (sent_total < REQUEST_TARGET) begin
      calm <= ($urandom_range(5) == 0);
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(4) != 0) begin
          send_request(KIND_REFILL, $urandom, ITEM_W'($urandom));
        end
        ops = $urandom_range(70, 10);
        repeat (ops) send_random_op();
      end else begin
        ops = $urandom_range(20, 5);
        repeat (ops) begin
          send_request(kind_e'($urandom_range(3)), pick_word(),
                       ITEM_W'($urandom_range(63)));
        end
      end
      if ($urandom_range(7) == 0) begin
        wait_until_drained();
      end
    end

    calm <= 1'b0;
    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests: %0d refills, %0d draws, %0d removes, %0d no-ops.",
             sent_total, sent_by_kind[KIND_REFILL], sent_by_kind[KIND_DRAW],
             sent_by_kind[KIND_REMOVE], sent_by_kind[KIND_NOP]);
    $display("Checked %0d results, %0d draws from an empty pool, %0d removes of absent items.",
             checked_count, empty_draws, absent_removes);
    if (fail_count == 0 && due_count == 0) begin
      $display("random_draw_pool_core_tb passed");
    end else begin
      $display("random_draw_pool_core_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/rdp_pkg.sv
hdl/random_draw_pool_core.sv
bench/random_draw_pool_core_checker.sv
bench/random_draw_pool_core_tb.sv
